/* src/adcr_pkg.sv */
// shared constants, types and register codes for the averaging adc reading block
// no dependencies; imported by every other file in src
package adcr_pkg;

  localparam int unsigned SAMPLES_PER_READING = 10;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned ADC_MAX   = 1023;
  localparam int unsigned RES_W     = 20;
  localparam int unsigned READ_W    = 40;
  localparam int unsigned FRAC_W    = 4;

  // full-scale group sum and derived widths
  localparam int unsigned FULL_SUM  = ADC_MAX * SAMPLES_PER_READING;
  localparam int unsigned SUM_W     = $clog2(FULL_SUM + 1);
  localparam int unsigned CNT_W     = $clog2(SAMPLES_PER_READING + 1);
  localparam int unsigned PROD_W    = SUM_W + RES_W;
  // dividend is (x << (FRAC_W+1)) + d, one spare bit for the carry
  localparam int unsigned NUM_RAW_W = PROD_W + FRAC_W + 2;
  localparam int unsigned NUM_W     = (NUM_RAW_W > READ_W) ? NUM_RAW_W : READ_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);
  localparam int unsigned DEN_W     = SUM_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [READ_W-1:0] READ_MAX = {READ_W{1'b1}};

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_RES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMART_MODE = 2'd2;

  // one completed group handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             force_post;
  } grp_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [RES_W-1:0]  split_res;
    logic [READ_W-1:0] threshold;
    logic              smart_mode;
  } cfg_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_CLAMP = 7'b0010000,
    S_DIFF  = 7'b0100000,
    S_POST  = 7'b1000000
  } back_state_e;

endpackage

/* src/adcr_in_if.sv */
// sample channel: valid/ready handshake with one adc sample and its flags
// depends on adcr_pkg for field widths
interface adcr_in_if;
  logic                           valid;
  logic                           ready;
  logic [adcr_pkg::SAMPLE_W-1:0]  sample;
  logic                           force_post;
  logic                           hold;

  modport source (output valid, output sample, output force_post, output hold, input ready);
  modport sink   (input valid, input sample, input force_post, input hold, output ready);
endinterface

/* src/adcr_out_if.sv */
// reading channel: valid/ready handshake with one q.4 reading and its flags
// depends on adcr_pkg for field widths
interface adcr_out_if;
  logic                          valid;
  logic                          ready;
  logic [adcr_pkg::READ_W-1:0]   reading;
  logic                          post;
  logic                          saturated;

  modport source (output valid, output reading, output post, output saturated, input ready);
  modport sink   (input valid, input reading, input post, input saturated, output ready);
endinterface

/* src/adcr_front.sv */
// front end: accumulates accepted samples and emits one group sum per full group
// depends on adcr_pkg and adcr_in_if
module adcr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  adcr_in_if.sink           in_i,
  output logic              push_valid_o,
  output adcr_pkg::grp_t    push_data_o,
  input  logic              push_ready_i
);
  import adcr_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             take;
  logic             last;
  logic [SUM_W-1:0] sum_next;

  // a sample may close a group, so only take it when the queue has room
  assign in_i.ready = push_ready_i;
  assign take       = in_i.valid & in_i.ready & ~in_i.hold;
  assign last       = (cnt_q == CNT_W'(SAMPLES_PER_READING - 1));
  assign sum_next   = sum_q + SUM_W'(in_i.sample);

  assign push_valid_o           = take & last;
  assign push_data_o.sum        = sum_next;
  assign push_data_o.force_post = in_i.force_post;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (take) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* src/adcr_queue.sv */
// short fifo of group sums between front and back ends
// depends on adcr_pkg
module adcr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  adcr_pkg::grp_t    push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output adcr_pkg::grp_t    pop_data_o,
  input  logic              pop_ready_i
);
  import adcr_pkg::*;

  grp_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* src/adcr_back.sv */
// back end: turns a group sum into a rounded q.4 reading with a bit-serial
// divider, applies the deadband and drives the output register
// depends on adcr_pkg and adcr_out_if
module adcr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  adcr_pkg::cfg_t    cfg_i,
  input  logic              pop_valid_i,
  input  adcr_pkg::grp_t    pop_data_i,
  output logic              pop_ready_o,
  adcr_out_if.source        out_o
);
  import adcr_pkg::*;

  back_state_e state_q, state_d;

  logic [SUM_W-1:0]     sum_q;
  logic                 force_q;
  logic                 plain_q;
  logic [PROD_W-1:0]    prod_q;
  logic [SUM_W-1:0]     d_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] bit_cnt_q;
  logic [READ_W-1:0]    reading_q;
  logic                 sat_q;
  logic [READ_W-1:0]    diff_q;
  logic [READ_W-1:0]    last_q;
  logic                 last_valid_q;

  logic                 out_valid_q;
  logic [READ_W-1:0]    out_reading_q;
  logic                 out_post_q;
  logic                 out_sat_q;

  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       divisor;
  logic                 ge;
  logic [DEN_W:0]       trial_sub;
  logic                 sat_case;
  logic                 post_w;
  logic                 out_free;
  logic [NUM_W-1:0]     x_ext;

  assign pop_ready_o = (state_q == S_IDLE);

  // restoring division, one quotient bit per cycle; divisor is 2*d
  assign divisor   = {1'b0, d_q, 1'b0};
  assign trial     = {rem_q, num_q[NUM_W-1]};
  assign ge        = (trial >= divisor);
  assign trial_sub = trial - divisor;

  assign sat_case = (cfg_i.split_res != '0) && (sum_q >= SUM_W'(FULL_SUM));
  assign x_ext    = plain_q ? NUM_W'(sum_q) : NUM_W'(prod_q);

  assign post_w   = force_q |
                    (cfg_i.smart_mode & last_valid_q & (diff_q > cfg_i.threshold));
  assign out_free = ~out_valid_q | out_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (pop_valid_i) state_d = S_MUL;
      S_MUL:   state_d = sat_case ? S_DIFF : S_LOAD;
      S_LOAD:  state_d = S_DIV;
      S_DIV:   if (bit_cnt_q == DIV_CNT_W'(NUM_W - 1)) state_d = S_CLAMP;
      S_CLAMP: state_d = S_DIFF;
      S_DIFF:  state_d = S_POST;
      S_POST:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bit_cnt_q    <= '0;
      last_valid_q <= 1'b0;
      last_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD) begin
        bit_cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        bit_cnt_q <= bit_cnt_q + DIV_CNT_W'(1);
      end
      if (state_q == S_POST && out_free) begin
        out_valid_q <= 1'b1;
        if (cfg_i.smart_mode && post_w) begin
          last_q       <= reading_q;
          last_valid_q <= 1'b1;
        end
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        sum_q   <= pop_data_i.sum;
        force_q <= pop_data_i.force_post;
      end
      S_MUL: begin
        plain_q <= (cfg_i.split_res == '0);
        prod_q  <= PROD_W'(sum_q) * PROD_W'(cfg_i.split_res);
        d_q     <= (cfg_i.split_res == '0) ? SUM_W'(SAMPLES_PER_READING)
                                           : SUM_W'(FULL_SUM) - sum_q;
        sat_q   <= sat_case;
        if (sat_case) begin
          reading_q <= READ_MAX;
        end
      end
      S_LOAD: begin
        // rounding addend d, divisor 2d, scale by 32 for q.4 plus half step
        num_q <= (x_ext << (FRAC_W + 1)) + NUM_W'(d_q);
        rem_q <= '0;
      end
      S_DIV: begin
        num_q <= {num_q[NUM_W-2:0], ge};
        rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      end
      S_CLAMP: begin
        reading_q <= (|num_q[NUM_W-1:READ_W]) ? READ_MAX : num_q[READ_W-1:0];
      end
      S_DIFF: begin
        diff_q <= (last_q > reading_q) ? last_q - reading_q : reading_q - last_q;
      end
      S_POST: begin
        if (out_free) begin
          out_reading_q <= reading_q;
          out_post_q    <= post_w;
          out_sat_q     <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.reading   = out_reading_q;
  assign out_o.post      = out_post_q;
  assign out_o.saturated = out_sat_q;

endmodule

/* src/adc_average_divider_change_report.sv */
// channel  | dir | fields                         | handshake
// in_i     | in  | sample[9:0] force_post hold    | valid/ready, accepted on valid & ready
// out_o    | out | reading[39:0] post saturated   | valid/ready, accepted on valid & ready
// cfg      | in  | cfg_we_i cfg_idx_i cfg_data_i  | write on cfg_we_i, no read-back
//
// samples are taken one per cycle while the group queue has room; a held sample
// is dropped. each tenth sample closes a group that the back end turns into a
// reading with the one-bit-per-cycle restoring divider; a saturated group skips
// the divider. the queue holds two groups, so the front stalls only when both
// are waiting. rst_ni clears the control state, counters and configuration, but
// not the back-end datapath registers or the queue storage; the reading register
// holds its value under output stall and the back end waits in its post step.
module adc_average_divider_change_report (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  adcr_in_if.sink                            in_i,
  adcr_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [adcr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [adcr_pkg::CFG_W-1:0]         cfg_data_i
);
  import adcr_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  grp_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPLIT_RES:  cfg_q.split_res  <= cfg_data_i[RES_W-1:0];
        CFG_THRESHOLD:  cfg_q.threshold  <= cfg_data_i[READ_W-1:0];
        CFG_SMART_MODE: cfg_q.smart_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  adcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  adcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  adcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
